FILE: rtl/pss_pkg.sv
`default_nettype none

package pss_pkg;

   localparam int unsigned ANGLE_W    = 12;
   localparam int unsigned STRENGTH_W = 7;
   localparam int unsigned DURATION_W = 10;
   localparam int unsigned DRIVE_W    = 8;
   localparam int unsigned PHASE_W    = 4;
   localparam int unsigned DETECT_W   = 6;
   localparam int unsigned OUTER_W    = 6;
   localparam int unsigned INNER_W    = 3;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 10;

   localparam logic [ANGLE_W-1:0] WIN_LOW    = 12'd1700;
   localparam logic [ANGLE_W-1:0] WIN_HIGH   = 12'd2300;
   localparam logic [ANGLE_W-1:0] LIMIT_LOW  = 12'd1000;
   localparam logic [ANGLE_W-1:0] LIMIT_HIGH = 12'd3000;
   localparam logic [DETECT_W-1:0] DETECT_LAST = 6'd40;
   localparam logic [OUTER_W-1:0]  OUTER_LAST  = 6'd50;
   localparam logic [INNER_W-1:0]  INNER_LAST  = 3'd5;
   localparam logic [ANGLE_W:0]    TURN_MARGIN = 13'd2;

   localparam logic [STRENGTH_W-1:0] STRENGTH_MAX   = 7'd100;
   localparam logic [STRENGTH_W-1:0] STRENGTH_RESET = 7'd40;
   localparam logic [DURATION_W-1:0] DURATION_RESET = 10'd100;

   localparam logic [CSR_IDX_W-1:0] REG_KICK_STRENGTH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KICK_DURATION = 1'd1;

   localparam logic OP_TICK   = 1'b0;
   localparam logic OP_BUTTON = 1'b1;

   localparam logic [PHASE_W-1:0] PH_STOP     = 4'd0;
   localparam logic [PHASE_W-1:0] PH_DETECT   = 4'd1;
   localparam logic [PHASE_W-1:0] PH_BALANCE  = 4'd2;
   localparam logic [PHASE_W-1:0] PH_R_PULSE1 = 4'd3;
   localparam logic [PHASE_W-1:0] PH_R_WAIT1  = 4'd4;
   localparam logic [PHASE_W-1:0] PH_R_PULSE2 = 4'd5;
   localparam logic [PHASE_W-1:0] PH_R_WAIT2  = 4'd6;
   localparam logic [PHASE_W-1:0] PH_L_PULSE1 = 4'd7;
   localparam logic [PHASE_W-1:0] PH_L_WAIT1  = 4'd8;
   localparam logic [PHASE_W-1:0] PH_L_PULSE2 = 4'd9;
   localparam logic [PHASE_W-1:0] PH_L_WAIT2  = 4'd10;

   typedef struct packed {
      logic                      drive_write;
      logic signed [DRIVE_W-1:0] drive_value;
      logic                      balance_start;
      logic                      outer_loop_due;
      logic                      inner_loop_due;
      logic                      running;
      logic [PHASE_W-1:0]        phase;
   } result_type;

   function automatic logic in_window(input logic [ANGLE_W-1:0] a);
      in_window = (a > WIN_LOW) && (a < WIN_HIGH);
   endfunction

endpackage

`default_nettype wire

FILE: rtl/pss_core.sv
`default_nettype none

module pss_core (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  advance,
   input  wire logic                                  operation,
   input  wire logic [pss_pkg::ANGLE_W-1:0]           angle_sample,
   input  wire logic [pss_pkg::STRENGTH_W-1:0]        kick_strength,
   input  wire logic [pss_pkg::DURATION_W-1:0]        kick_duration,
   output pss_pkg::result_type                        result
);

   logic [pss_pkg::PHASE_W-1:0]    phase_ff, phase_in;
   logic [pss_pkg::DETECT_W-1:0]   detect_ff, detect_in;
   logic [pss_pkg::OUTER_W-1:0]    outer_ff, outer_in;
   logic [pss_pkg::INNER_W-1:0]    inner_ff, inner_in;
   logic [pss_pkg::ANGLE_W-1:0]    hist0_ff, hist0_in;
   logic [pss_pkg::ANGLE_W-1:0]    hist1_ff, hist1_in;
   logic [pss_pkg::ANGLE_W-1:0]    hist2_ff, hist2_in;
   logic [pss_pkg::DURATION_W-1:0] timer_ff, timer_in;

   logic [pss_pkg::STRENGTH_W-1:0] mag;
   logic signed [pss_pkg::DRIVE_W-1:0] mag_pos;
   logic [pss_pkg::DETECT_W-1:0]   detect_inc;
   logic [pss_pkg::OUTER_W-1:0]    outer_inc;
   logic [pss_pkg::INNER_W-1:0]    inner_inc;
   logic [pss_pkg::DURATION_W-1:0] timer_dec;
   logic [pss_pkg::ANGLE_W:0]      a0_w, a1_w, a2_w;
   logic                           turn_high, turn_low;

   assign mag = (kick_strength > pss_pkg::STRENGTH_MAX) ? pss_pkg::STRENGTH_MAX : kick_strength;
   assign mag_pos = signed'({1'b0, mag});
   assign detect_inc = detect_ff + 1'b1;
   assign outer_inc  = outer_ff + 1'b1;
   assign inner_inc  = inner_ff + 1'b1;
   assign timer_dec  = timer_ff - 1'b1;

   // candidate history after a shift: a0 is the new sample
   assign a0_w = {1'b0, angle_sample};
   assign a1_w = {1'b0, hist0_ff};
   assign a2_w = {1'b0, hist1_ff};

   assign turn_high = (angle_sample >= pss_pkg::WIN_HIGH) && (hist0_ff >= pss_pkg::WIN_HIGH) &&
                      (hist1_ff >= pss_pkg::WIN_HIGH) &&
                      (a1_w + pss_pkg::TURN_MARGIN < a0_w) && (a1_w + pss_pkg::TURN_MARGIN < a2_w);
   assign turn_low  = (angle_sample <= pss_pkg::WIN_LOW) && (hist0_ff <= pss_pkg::WIN_LOW) &&
                      (hist1_ff <= pss_pkg::WIN_LOW) &&
                      (a1_w > a0_w + pss_pkg::TURN_MARGIN) && (a1_w > a2_w + pss_pkg::TURN_MARGIN);

   always_comb begin
      phase_in  = phase_ff;
      detect_in = detect_ff;
      outer_in  = outer_ff;
      inner_in  = inner_ff;
      hist0_in  = hist0_ff;
      hist1_in  = hist1_ff;
      hist2_in  = hist2_ff;
      timer_in  = timer_ff;
      result    = '0;

      if (operation == pss_pkg::OP_BUTTON) begin
         phase_in = (phase_ff == pss_pkg::PH_STOP) ? pss_pkg::PH_R_PULSE2 : pss_pkg::PH_STOP;
      end else begin
         unique case (phase_ff)
            pss_pkg::PH_DETECT: begin
               if (detect_inc > pss_pkg::DETECT_LAST) begin
                  detect_in = '0;
                  hist0_in  = angle_sample;
                  hist1_in  = hist0_ff;
                  hist2_in  = hist1_ff;
                  if (pss_pkg::in_window(angle_sample) && pss_pkg::in_window(hist0_ff)) begin
                     result.balance_start = 1'b1;
                     phase_in = pss_pkg::PH_BALANCE;
                  end
                  if (turn_high) phase_in = pss_pkg::PH_R_PULSE1;
                  if (turn_low)  phase_in = pss_pkg::PH_L_PULSE1;
               end else begin
                  detect_in = detect_inc;
               end
            end
            pss_pkg::PH_BALANCE: begin
               if (outer_inc > pss_pkg::OUTER_LAST) begin
                  outer_in = '0;
                  result.outer_loop_due = 1'b1;
               end else begin
                  outer_in = outer_inc;
               end
               if (inner_inc > pss_pkg::INNER_LAST) begin
                  inner_in = '0;
                  result.inner_loop_due = 1'b1;
                  if (angle_sample > pss_pkg::LIMIT_HIGH || angle_sample < pss_pkg::LIMIT_LOW)
                     phase_in = pss_pkg::PH_STOP;
               end else begin
                  inner_in = inner_inc;
               end
            end
            pss_pkg::PH_R_PULSE1, pss_pkg::PH_R_PULSE2,
            pss_pkg::PH_L_PULSE1, pss_pkg::PH_L_PULSE2: begin
               result.drive_write = 1'b1;
               result.drive_value = (phase_ff == pss_pkg::PH_R_PULSE1 ||
                                     phase_ff == pss_pkg::PH_L_PULSE2) ? mag_pos : -mag_pos;
               timer_in = kick_duration;
               phase_in = phase_ff + 1'b1;
            end
            pss_pkg::PH_R_WAIT1, pss_pkg::PH_R_WAIT2,
            pss_pkg::PH_L_WAIT1, pss_pkg::PH_L_WAIT2: begin
               timer_in = timer_dec;
               if (timer_dec == '0) begin
                  if (phase_ff == pss_pkg::PH_R_WAIT2 || phase_ff == pss_pkg::PH_L_WAIT2) begin
                     result.drive_write = 1'b1;
                     phase_in = pss_pkg::PH_DETECT;
                  end else begin
                     phase_in = phase_ff + 1'b1;
                  end
               end
            end
            default: begin
               // stopped or an unused code: force drive off and stop
               result.drive_write = 1'b1;
               phase_in = pss_pkg::PH_STOP;
            end
         endcase
      end

      result.phase   = phase_in;
      result.running = (phase_in != pss_pkg::PH_STOP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= pss_pkg::PH_STOP;
         detect_ff <= '0;
         outer_ff  <= '0;
         inner_ff  <= '0;
         hist0_ff  <= '0;
         hist1_ff  <= '0;
         hist2_ff  <= '0;
         timer_ff  <= '0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         detect_ff <= detect_in;
         outer_ff  <= outer_in;
         inner_ff  <= inner_in;
         hist0_ff  <= hist0_in;
         hist1_ff  <= hist1_in;
         hist2_ff  <= hist2_in;
         timer_ff  <= timer_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/pendulum_swing_up_sequencer_top.sv
// A result shows on rsp_* after its item has passed the input register and then the result
// register; rsp_stall can hold it back longer.
// Throughput: one item per cycle while rsp_stall does not hold the output; the single
// next-state step between the two registers sets that figure.
// Reset: synchronous, active high; clears phase to stop, counters, angle history and
// kick timer, and loads kick_strength = 40 and kick_duration = 100.
`default_nettype none

module pendulum_swing_up_sequencer_top (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output      logic                                  req_stall,
   input  wire logic                                  req_operation,
   input  wire logic [pss_pkg::ANGLE_W-1:0]           req_angle_sample,
   output      logic                                  rsp_valid,
   input  wire logic                                  rsp_stall,
   output      logic                                  rsp_drive_write,
   output      logic signed [pss_pkg::DRIVE_W-1:0]    rsp_drive_value,
   output      logic                                  rsp_balance_start,
   output      logic                                  rsp_outer_loop_due,
   output      logic                                  rsp_inner_loop_due,
   output      logic                                  rsp_running,
   output      logic [pss_pkg::PHASE_W-1:0]           rsp_phase,
   input  wire logic                                  csr_valid,
   output      logic                                  csr_ready,
   input  wire logic [pss_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [pss_pkg::CSR_DATA_W-1:0]        csr_data
);

   logic                               in_valid_ff;
   logic                               in_op_ff;
   logic [pss_pkg::ANGLE_W-1:0]        in_angle_ff;
   logic                               out_valid_ff;
   pss_pkg::result_type                out_ff;
   pss_pkg::result_type                step_result;
   logic [pss_pkg::STRENGTH_W-1:0]     strength_ff;
   logic [pss_pkg::DURATION_W-1:0]     duration_ff;
   logic                               out_free;
   logic                               advance;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign csr_ready = 1'b1;

   pss_core u_core (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .operation     (in_op_ff),
      .angle_sample  (in_angle_ff),
      .kick_strength (strength_ff),
      .kick_duration (duration_ff),
      .result        (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         strength_ff <= pss_pkg::STRENGTH_RESET;
         duration_ff <= pss_pkg::DURATION_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pss_pkg::REG_KICK_STRENGTH: strength_ff <= csr_data[pss_pkg::STRENGTH_W-1:0];
            pss_pkg::REG_KICK_DURATION: duration_ff <= csr_data[pss_pkg::DURATION_W-1:0];
            default: ;
         endcase
      end
   end

   // input register: take a new item whenever the held one moves on or is absent
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_op_ff    <= req_operation;
         in_angle_ff <= req_angle_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= step_result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_drive_write    = out_ff.drive_write;
   assign rsp_drive_value    = out_ff.drive_value;
   assign rsp_balance_start  = out_ff.balance_start;
   assign rsp_outer_loop_due = out_ff.outer_loop_due;
   assign rsp_inner_loop_due = out_ff.inner_loop_due;
   assign rsp_running        = out_ff.running;
   assign rsp_phase          = out_ff.phase;

endmodule

`default_nettype wire

FILE: tb/sv/pss_result_checker.sv
`timescale 1ns / 1ps

module pss_result_checker
   import pss_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   input  wire logic                      req_stall,
   input  wire logic                      req_operation,
   input  wire logic [ANGLE_W-1:0]        req_angle_sample,
   input  wire logic                      rsp_valid,
   input  wire logic                      rsp_stall,
   input  wire logic                      rsp_drive_write,
   input  wire logic signed [DRIVE_W-1:0] rsp_drive_value,
   input  wire logic                      rsp_balance_start,
   input  wire logic                      rsp_outer_loop_due,
   input  wire logic                      rsp_inner_loop_due,
   input  wire logic                      rsp_running,
   input  wire logic [PHASE_W-1:0]        rsp_phase,
   input  wire logic                      csr_valid,
   input  wire logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0]      csr_index,
   input  wire logic [CSR_DATA_W-1:0]     csr_data,
   output int                             fail_count,
   output int                             pending_count,
   output int                             checked_count
);

   // predictor copy of the sequencer state and its settings
   logic [PHASE_W-1:0]    phase_q;
   logic [DETECT_W-1:0]   detect_q;
   logic [OUTER_W-1:0]    outer_q;
   logic [INNER_W-1:0]    inner_q;
   logic [ANGLE_W-1:0]    history_q [3];
   logic [DURATION_W-1:0] timer_q;
   logic [STRENGTH_W-1:0] strength_q;
   logic [DURATION_W-1:0] duration_q;

   result_type predicted_results [$];
   int mismatches = 0;
   int compared = 0;

   function automatic logic inside_window(input logic [ANGLE_W-1:0] a);
      return (a > WIN_LOW) && (a < WIN_HIGH);
   endfunction

   function automatic result_type advance_sequencer(input logic                op,
                                                    input logic [ANGLE_W-1:0] angle);
      result_type               r;
      logic [ANGLE_W:0]         a0, a1, a2;
      logic [STRENGTH_W-1:0]    mag;
      logic signed [DRIVE_W-1:0] kick;
      r = '0;
      mag = (strength_q > STRENGTH_MAX) ? STRENGTH_MAX : strength_q;
      kick = {1'b0, mag};
      if (op == OP_BUTTON) begin
         phase_q = (phase_q == PH_STOP) ? PH_R_PULSE2 : PH_STOP;
      end else begin
         case (phase_q)
            PH_DETECT: begin
               detect_q = detect_q + 1'b1;
               if (detect_q > DETECT_LAST) begin
                  detect_q = '0;
                  history_q[2] = history_q[1];
                  history_q[1] = history_q[0];
                  history_q[0] = angle;
                  a0 = {1'b0, history_q[0]};
                  a1 = {1'b0, history_q[1]};
                  a2 = {1'b0, history_q[2]};
                  if (inside_window(history_q[0]) && inside_window(history_q[1])) begin
                     r.balance_start = 1'b1;
                     phase_q = PH_BALANCE;
                  end
                  // swing turned at the high side: kick right first
                  if (a0 >= WIN_HIGH && a1 >= WIN_HIGH && a2 >= WIN_HIGH &&
                      a1 + TURN_MARGIN < a0 && a1 + TURN_MARGIN < a2)
                     phase_q = PH_R_PULSE1;
                  if (a0 <= WIN_LOW && a1 <= WIN_LOW && a2 <= WIN_LOW &&
                      a1 > a0 + TURN_MARGIN && a1 > a2 + TURN_MARGIN)
                     phase_q = PH_L_PULSE1;
               end
            end
            PH_BALANCE: begin
               outer_q = outer_q + 1'b1;
               if (outer_q > OUTER_LAST) begin
                  outer_q = '0;
                  r.outer_loop_due = 1'b1;
               end
               inner_q = inner_q + 1'b1;
               if (inner_q > INNER_LAST) begin
                  inner_q = '0;
                  r.inner_loop_due = 1'b1;
                  if (angle > LIMIT_HIGH || angle < LIMIT_LOW)
                     phase_q = PH_STOP;
               end
            end
            PH_R_PULSE1, PH_R_PULSE2, PH_L_PULSE1, PH_L_PULSE2: begin
               r.drive_write = 1'b1;
               r.drive_value = (phase_q == PH_R_PULSE1 || phase_q == PH_L_PULSE2) ? kick : -kick;
               timer_q = duration_q;
               phase_q = phase_q + 1'b1;
            end
            PH_R_WAIT1, PH_R_WAIT2, PH_L_WAIT1, PH_L_WAIT2: begin
               timer_q = timer_q - 1'b1;
               if (timer_q == '0) begin
                  if (phase_q == PH_R_WAIT2 || phase_q == PH_L_WAIT2) begin
                     r.drive_write = 1'b1;
                     phase_q = PH_DETECT;
                  end else begin
                     phase_q = phase_q + 1'b1;
                  end
               end
            end
            default: begin
               r.drive_write = 1'b1;
               phase_q = PH_STOP;
            end
         endcase
      end
      r.running = (phase_q != PH_STOP);
      r.phase = phase_q;
      return r;
   endfunction

   task automatic compare_field(input string field, input int want, input int got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         phase_q = PH_STOP;
         detect_q = '0;
         outer_q = '0;
         inner_q = '0;
         history_q[0] = '0;
         history_q[1] = '0;
         history_q[2] = '0;
         timer_q = '0;
         strength_q = STRENGTH_RESET;
         duration_q = DURATION_RESET;
         predicted_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_results.size() == 0) begin
               mismatches++;
               $display("%0t: result with no item pending, expected none, actual phase %0d",
                        $time, rsp_phase);
            end else begin
               want = predicted_results.pop_front();
               compare_field("drive_write", int'(want.drive_write), int'(rsp_drive_write));
               compare_field("drive_value", int'(want.drive_value), int'(rsp_drive_value));
               compare_field("balance_start", int'(want.balance_start),
                             int'(rsp_balance_start));
               compare_field("outer_loop_due", int'(want.outer_loop_due),
                             int'(rsp_outer_loop_due));
               compare_field("inner_loop_due", int'(want.inner_loop_due),
                             int'(rsp_inner_loop_due));
               compare_field("running", int'(want.running), int'(rsp_running));
               compare_field("phase", int'(want.phase), int'(rsp_phase));
               compared++;
            end
         end
         if (req_valid && !req_stall)
            predicted_results.push_back(advance_sequencer(req_operation, req_angle_sample));
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_KICK_STRENGTH)
               strength_q = csr_data[STRENGTH_W-1:0];
            else
               duration_q = csr_data[DURATION_W-1:0];
         end
      end
      fail_count <= mismatches;
      pending_count <= predicted_results.size();
      checked_count <= compared;
   end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import pss_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_TICKS  = 41;   // detect takes one sample per 41 ticks
   localparam int SQUEEZE_LEN = 300;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   wire                       req_stall;
   logic                      req_operation = OP_TICK;
   logic [ANGLE_W-1:0]        req_angle_sample = '0;
   wire                       rsp_valid;
   logic                      rsp_stall = 1'b0;
   wire                       rsp_drive_write;
   wire signed [DRIVE_W-1:0]  rsp_drive_value;
   wire                       rsp_balance_start;
   wire                       rsp_outer_loop_due;
   wire                       rsp_inner_loop_due;
   wire                       rsp_running;
   wire [PHASE_W-1:0]         rsp_phase;
   logic                      csr_valid = 1'b0;
   wire                       csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index = REG_KICK_STRENGTH;
   logic [CSR_DATA_W-1:0]     csr_data = '0;

   int fail_count;
   int pending_count;
   int checked_count;
   int items_sent = 0;
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int cycles = 0;
   logic [PHASE_W-1:0]    seen_phase = PH_STOP;
   logic [DURATION_W-1:0] cur_duration = DURATION_RESET;
   logic squeeze_req = 1'b0;
   logic squeeze_done = 1'b0;

   pendulum_swing_up_sequencer_top u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_angle_sample   (req_angle_sample),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_drive_write    (rsp_drive_write),
      .rsp_drive_value    (rsp_drive_value),
      .rsp_balance_start  (rsp_balance_start),
      .rsp_outer_loop_due (rsp_outer_loop_due),
      .rsp_inner_loop_due (rsp_inner_loop_due),
      .rsp_running        (rsp_running),
      .rsp_phase          (rsp_phase),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   pss_result_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_angle_sample   (req_angle_sample),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_drive_write    (rsp_drive_write),
      .rsp_drive_value    (rsp_drive_value),
      .rsp_balance_start  (rsp_balance_start),
      .rsp_outer_loop_due (rsp_outer_loop_due),
      .rsp_inner_loop_due (rsp_inner_loop_due),
      .rsp_running        (rsp_running),
      .rsp_phase          (rsp_phase),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .fail_count         (fail_count),
      .pending_count      (pending_count),
      .checked_count      (checked_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // track the phase the block last reported, to steer the next sequence
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         seen_phase <= rsp_phase;
   end

   // output side: random stall, plus one long hold to back the block up
   initial begin
      forever begin
         @(posedge clock);
         if (squeeze_req && !squeeze_done) begin
            rsp_stall <= 1'b1;
            repeat (SQUEEZE_LEN) @(posedge clock);
            squeeze_done = 1'b1;
         end
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   task automatic send_item(input logic op, input logic [ANGLE_W-1:0] angle);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_angle_sample <= angle;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic noise_ticks(input int count);
      repeat (count) send_item(OP_TICK, ANGLE_W'($urandom_range(4095)));
   endtask

   // hold one angle long enough that detect samples it exactly once
   task automatic hold_angle(input logic [ANGLE_W-1:0] angle);
      repeat (HOLD_TICKS) send_item(OP_TICK, angle);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic set_kick(input logic [STRENGTH_W-1:0] magnitude,
                           input logic [DURATION_W-1:0] duration);
      logic [CSR_DATA_W-STRENGTH_W-1:0] spare_bits;
      spare_bits = (CSR_DATA_W - STRENGTH_W)'($urandom);
      drain();
      repeat (3) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= REG_KICK_STRENGTH;
      csr_data <= {spare_bits, magnitude};
      do @(posedge clock); while (!csr_ready);
      csr_index <= REG_KICK_DURATION;
      csr_data <= duration;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_duration = duration;
   endtask

   // turning-point step: mostly clear turns, sometimes within the margin
   function automatic int turn_step();
      return ($urandom_range(3) == 0) ? $urandom_range(3) : $urandom_range(95, 3);
   endfunction

   task automatic run_episodes(input int quota);
      int stop_at;
      int mid;
      int pick;
      int len;
      logic [ANGLE_W-1:0] angle;
      stop_at = items_sent + quota;
      while (items_sent < stop_at) begin
         drain();
         case (seen_phase)
            PH_STOP: begin
               if ($urandom_range(7) == 0)
                  noise_ticks($urandom_range(4, 1));
               else
                  send_item(OP_BUTTON, ANGLE_W'($urandom_range(4095)));
            end
            PH_DETECT: begin
               pick = $urandom_range(9);
               if (pick <= 2) begin
                  mid = $urandom_range(4000, WIN_HIGH);
                  hold_angle(ANGLE_W'(mid + turn_step()));
                  hold_angle(ANGLE_W'(mid));
                  hold_angle(ANGLE_W'(mid + turn_step()));
               end else if (pick <= 5) begin
                  mid = $urandom_range(WIN_LOW, 95);
                  hold_angle(ANGLE_W'(mid - turn_step()));
                  hold_angle(ANGLE_W'(mid));
                  hold_angle(ANGLE_W'(mid - turn_step()));
               end else if (pick <= 7) begin
                  repeat (2) begin
                     if ($urandom_range(5) == 0)
                        angle = $urandom_range(1) ? WIN_LOW : WIN_HIGH;
                     else
                        angle = ANGLE_W'($urandom_range(WIN_HIGH - 1, WIN_LOW + 1));
                     hold_angle(angle);
                  end
               end else if (pick == 8) begin
                  noise_ticks($urandom_range(60, 1));
               end else begin
                  send_item(OP_BUTTON, ANGLE_W'($urandom_range(4095)));
               end
            end
            PH_BALANCE: begin
               len = $urandom_range(70, 6);
               repeat (len) begin
                  angle = ANGLE_W'($urandom_range(LIMIT_HIGH, LIMIT_LOW));
                  // probe the stop limits now and then
                  if ($urandom_range(19) == 0) begin
                     case ($urandom_range(5))
                        0: angle = '0;
                        1: angle = LIMIT_LOW - 1'b1;
                        2: angle = LIMIT_LOW;
                        3: angle = LIMIT_HIGH;
                        4: angle = LIMIT_HIGH + 1'b1;
                        default: angle = '1;
                     endcase
                  end
                  send_item(OP_TICK, angle);
               end
               if ($urandom_range(9) == 0)
                  send_item(OP_BUTTON, ANGLE_W'($urandom_range(4095)));
            end
            default: noise_ticks($urandom_range(2 * cur_duration + 3, 1));
         endcase
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset settings: stop ticks, start kick, button from a kick phase
      send_item(OP_TICK, 12'h000);
      send_item(OP_TICK, 12'hFFF);
      send_item(OP_BUTTON, 12'hFFF);
      send_item(OP_TICK, 12'h000);
      send_item(OP_TICK, 12'hAAA);
      send_item(OP_BUTTON, 12'h000);
      send_item(OP_BUTTON, 12'h555);
      send_item(OP_BUTTON, 12'hAAA);

      // strength above the ceiling saturates; shortest kick
      set_kick(7'd127, 10'd1);
      send_item(OP_BUTTON, 12'h000);
      send_item(OP_TICK, 12'h555);
      send_item(OP_TICK, 12'hFFF);
      send_item(OP_BUTTON, 12'h000);

      // zero strength, kick_duration at its largest value loaded then cut short
      set_kick(7'd0, 10'd1023);
      send_item(OP_BUTTON, 12'h000);
      send_item(OP_TICK, 12'h123);
      send_item(OP_TICK, 12'hEDC);
      send_item(OP_TICK, 12'h800);
      send_item(OP_BUTTON, 12'h7FF);

      // zero duration: the timer wraps to the top, then stop the long wait
      set_kick(STRENGTH_MAX, 10'd0);
      send_item(OP_BUTTON, 12'h000);
      send_item(OP_TICK, ANGLE_W'($urandom_range(4095)));
      noise_ticks(60);
      send_item(OP_BUTTON, 12'h000);

      set_kick(STRENGTH_W'($urandom_range(100, 1)), DURATION_W'($urandom_range(6, 1)));
      req_idle_pct = 25;
      rsp_idle_pct = 49;
      run_episodes(280);

      set_kick(STRENGTH_MAX, DURATION_W'($urandom_range(3, 1)));
      req_idle_pct = 49;
      rsp_idle_pct = 25;
      run_episodes(280);

      set_kick(STRENGTH_W'($urandom_range(127, 101)), DURATION_W'($urandom_range(10, 1)));
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      squeeze_req <= 1'b1;
      noise_ticks(40);
      run_episodes(280);

      drain();
      repeat (10) @(posedge clock);
      $display("Covered %0d items: directed edges, kick timer wrap, three stall mixes",
               items_sent);
      $display("and one long output hold; %0d results compared", checked_count);
      if (fail_count == 0 && pending_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

FILE: pendulum_swing_up_sequencer_top.f
rtl/pss_pkg.sv
rtl/pss_core.sv
rtl/pendulum_swing_up_sequencer_top.sv
tb/sv/pss_result_checker.sv
tb/sv/testbench.sv
